// ----- hdl/ddo_pkg.sv -----
package ddo_pkg;

    localparam int FRAC_BITS         = 16;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANG_SHIFT         = 30 - FRAC_BITS;

    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_N  = 44;
    localparam int DIV_D  = 24;
    localparam int TRIG_W = 18;
    localparam int ANG_W  = 35;
    localparam int CRD_W  = 33;
    localparam int ARC_N  = 24;

    localparam logic [18:0] TWO_PI_Q = 19'd411775;
    localparam logic [23:0] W_FLOOR  = 24'(((2 ** FRAC_BITS) + 999) / 1000);

    localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CRD_W-1:0] GAIN_Q30    = 33'sd652032874;

    localparam logic REG_WHEEL_BASE   = 1'b0;
    localparam logic REG_WHEEL_RADIUS = 1'b1;

    localparam logic REQ_VELOCITY = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    function automatic logic [29:0] arc_angle(input logic [4:0] idx);
        logic [29:0] a;
        case (idx)
            5'd0:  a = 30'd843314857;
            5'd1:  a = 30'd497837829;
            5'd2:  a = 30'd263043837;
            5'd3:  a = 30'd133525159;
            5'd4:  a = 30'd67021687;
            5'd5:  a = 30'd33543516;
            5'd6:  a = 30'd16775851;
            5'd7:  a = 30'd8388437;
            5'd8:  a = 30'd4194283;
            5'd9:  a = 30'd2097149;
            5'd10: a = 30'd1048576;
            5'd11: a = 30'd524288;
            5'd12: a = 30'd262144;
            5'd13: a = 30'd131072;
            5'd14: a = 30'd65536;
            5'd15: a = 30'd32768;
            5'd16: a = 30'd16384;
            5'd17: a = 30'd8192;
            5'd18: a = 30'd4096;
            5'd19: a = 30'd2048;
            5'd20: a = 30'd1024;
            5'd21: a = 30'd512;
            5'd22: a = 30'd256;
            5'd23: a = 30'd128;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- hdl/diff_drive_odometry.sv -----
// Differential-drive odometry. A velocity command (req_type 0) stores linear and
// angular speed and returns the left and right wheel speeds; an odometry tick
// (req_type 1) advances the pose by arc integration over tick_dt and returns it
// with zero wheel speeds. One item is processed at a time; the result sits in an
// output register, so the next item can be taken while it waits. A command runs
// a multiply and two divisions; a tick runs a multiply, a heading reduction by
// division, two CORDIC evaluations, and a multiply and a division for each of x
// and y. The steps use the bit-serial shift-add multiplier, the one-bit-per-cycle
// restoring divider and the iterative CORDIC.
// Wheel base and radius are to be written by the user through cfg_* while the
// block is idle; the block itself does not enforce it.
module diff_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_ITERATIONS_P = CORDIC_ITERATIONS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [15:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic signed [23:0] s_linear_velocity,
    input  logic signed [23:0] s_angular_velocity,
    input  logic [19:0]        s_tick_dt,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [28:0] m_left_wheel_speed,
    output logic signed [28:0] m_right_wheel_speed,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic [18:0]        m_out_heading
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_C_MUL  = 4'd1;
    localparam logic [3:0] ST_C_DIVR = 4'd2;
    localparam logic [3:0] ST_C_DIVL = 4'd3;
    localparam logic [3:0] ST_T_MUL  = 4'd4;
    localparam logic [3:0] ST_T_MOD  = 4'd5;
    localparam logic [3:0] ST_T_COS1 = 4'd6;
    localparam logic [3:0] ST_T_COS2 = 4'd7;
    localparam logic [3:0] ST_T_MULX = 4'd8;
    localparam logic [3:0] ST_T_DIVX = 4'd9;
    localparam logic [3:0] ST_T_MULY = 4'd10;
    localparam logic [3:0] ST_T_DIVY = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    function automatic logic [23:0] abs24(input logic signed [23:0] v);
        return v[23] ? 24'(-v) : 24'(v);
    endfunction

    function automatic logic [28:0] sat29(input logic signed [44:0] v);
        if (v > 45'sd268435455) begin
            return 29'h0FFFFFFF;
        end else if (v < -45'sd268435456) begin
            return 29'h10000000;
        end
        return v[28:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [45:0] v);
        if (v > 46'sd2147483647) begin
            return 32'h7FFFFFFF;
        end else if (v < -46'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    logic [3:0] state_reg, state_next;
    logic [15:0] base_reg;
    logic [15:0] rad_reg;
    logic signed [23:0] lin_reg, lin_next;
    logic signed [23:0] ang_reg, ang_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic [18:0] hd_reg, hd_next;
    logic [18:0] nh_reg, nh_next;
    logic signed [TRIG_W-1:0] s1_reg, s1_next;
    logic signed [TRIG_W-1:0] c1_reg, c1_next;
    logic signed [18:0] dcy_reg, dcy_next;
    logic signed [41:0] numl_reg, numl_next;
    logic [28:0] left_reg, left_next;
    logic [28:0] right_reg, right_next;

    logic mul_start_reg, mul_start_next;
    logic [MUL_W-1:0] mul_a_reg, mul_a_next;
    logic [MUL_W-1:0] mul_b_reg, mul_b_next;
    logic mul_neg_reg, mul_neg_next;
    logic div_start_reg, div_start_next;
    logic [DIV_N-1:0] div_n_reg, div_n_next;
    logic [DIV_D-1:0] div_d_reg, div_d_next;
    logic div_neg_reg, div_neg_next;
    logic cor_start_reg, cor_start_next;
    logic [18:0] cor_ang_reg, cor_ang_next;

    logic m_valid_reg, m_valid_next;
    logic [28:0] ml_reg, ml_next;
    logic [28:0] mr_reg, mr_next;
    logic [31:0] mx_reg, mx_next;
    logic [31:0] my_reg, my_next;
    logic [18:0] mh_reg, mh_next;

    logic mul_done;
    logic [PROD_W-1:0] mul_prod;
    logic div_done;
    logic [DIV_N-1:0] div_quo;
    logic [DIV_D-1:0] div_rem;
    logic cor_done;
    logic signed [TRIG_W-1:0] cor_sin;
    logic signed [TRIG_W-1:0] cor_cos;

    logic [23:0] aw_ang;
    logic signed [23:0] w_eff;
    logic signed [41:0] rot_s;
    logic signed [41:0] lin_s;
    logic signed [41:0] num_r;
    logic signed [41:0] num_l;
    logic [41:0] mag_r;
    logic [41:0] mag_l;
    logic [15:0] rad_eff;
    logic [DIV_D-1:0] den_c;
    logic signed [45:0] wd;
    logic signed [45:0] wdr;
    logic signed [30:0] hsum;
    logic [30:0] hmag;
    logic [18:0] rmod;
    logic [18:0] nh_c;
    logic signed [18:0] dsx;
    logic signed [18:0] dcy_c;
    logic [18:0] dsx_mag;
    logic [18:0] dcy_mag;
    logic signed [44:0] qs;
    logic signed [45:0] sumx;
    logic signed [45:0] sumy;

    ddo_mul #(.AW(MUL_W), .BW(MUL_W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ddo_div #(.NW(DIV_N), .DW(DIV_D)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_n_reg),
        .den     (div_d_reg),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    ddo_cordic #(.ITER(CORDIC_ITERATIONS_P)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start_reg),
        .angle   (cor_ang_reg),
        .done    (cor_done),
        .sin_q   (cor_sin),
        .cos_q   (cor_cos)
    );

    // operand and result shaping around the serial units
    assign aw_ang  = abs24(ang_reg);
    assign w_eff   = (aw_ang < W_FLOOR) ? $signed(W_FLOOR) : ang_reg;
    assign rot_s   = mul_neg_reg ? -$signed(mul_prod[41:0]) : $signed(mul_prod[41:0]);
    assign lin_s   = 42'(lin_reg) <<< (FRAC_BITS + 1);
    assign num_r   = lin_s + rot_s;
    assign num_l   = lin_s - rot_s;
    assign mag_r   = num_r[41] ? 42'(-num_r) : 42'(num_r);
    assign mag_l   = numl_reg[41] ? 42'(-numl_reg) : 42'(numl_reg);
    assign rad_eff = (rad_reg == 16'd0) ? 16'd1 : rad_reg;
    assign den_c   = DIV_D'({rad_eff, 1'b0});
    assign wd      = mul_neg_reg ? -$signed({2'b00, mul_prod[43:0]})
                                 : $signed({2'b00, mul_prod[43:0]});
    assign wdr     = wd + (46'sd1 <<< (FRAC_BITS - 1));
    assign hsum    = $signed({12'b0, hd_reg}) + 31'($signed(wdr[45:FRAC_BITS]));
    assign hmag    = hsum[30] ? 31'(-hsum) : 31'(hsum);
    assign rmod    = div_rem[18:0];
    assign nh_c    = (div_neg_reg && rmod != 19'd0) ? TWO_PI_Q - rmod : rmod;
    assign dsx     = 19'(cor_sin) - 19'(s1_reg);
    assign dcy_c   = 19'(c1_reg) - 19'(cor_cos);
    assign dsx_mag = dsx[18] ? 19'(-dsx) : 19'(dsx);
    assign dcy_mag = dcy_reg[18] ? 19'(-dcy_reg) : 19'(dcy_reg);
    assign qs      = div_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign sumx    = 46'(px_reg) + 46'(qs);
    assign sumy    = 46'(py_reg) + 46'(qs);

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        lin_next       = lin_reg;
        ang_next       = ang_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        hd_next        = hd_reg;
        nh_next        = nh_reg;
        s1_next        = s1_reg;
        c1_next        = c1_reg;
        dcy_next       = dcy_reg;
        numl_next      = numl_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_neg_next   = mul_neg_reg;
        div_start_next = 1'b0;
        div_n_next     = div_n_reg;
        div_d_next     = div_d_reg;
        div_neg_next   = div_neg_reg;
        cor_start_next = 1'b0;
        cor_ang_next   = cor_ang_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        ml_next        = ml_reg;
        mr_next        = mr_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mh_next        = mh_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_VELOCITY) begin
                        lin_next       = s_linear_velocity;
                        ang_next       = s_angular_velocity;
                        mul_a_next     = abs24(s_angular_velocity);
                        mul_b_next     = MUL_W'(base_reg);
                        mul_neg_next   = s_angular_velocity[23];
                        mul_start_next = 1'b1;
                        state_next     = ST_C_MUL;
                    end else begin
                        ang_next       = w_eff;
                        mul_a_next     = abs24(w_eff);
                        mul_b_next     = MUL_W'(s_tick_dt);
                        mul_neg_next   = w_eff[23];
                        mul_start_next = 1'b1;
                        left_next      = '0;
                        right_next     = '0;
                        state_next     = ST_T_MUL;
                    end
                end
            end
            ST_C_MUL: begin
                if (mul_done) begin
                    numl_next      = num_l;
                    div_n_next     = DIV_N'(mag_r);
                    div_d_next     = den_c;
                    div_neg_next   = num_r[41];
                    div_start_next = 1'b1;
                    state_next     = ST_C_DIVR;
                end
            end
            ST_C_DIVR: begin
                if (div_done) begin
                    right_next     = sat29(qs);
                    div_n_next     = DIV_N'(mag_l);
                    div_neg_next   = numl_reg[41];
                    div_start_next = 1'b1;
                    state_next     = ST_C_DIVL;
                end
            end
            ST_C_DIVL: begin
                if (div_done) begin
                    left_next  = sat29(qs);
                    state_next = ST_FIN;
                end
            end
            ST_T_MUL: begin
                if (mul_done) begin
                    div_n_next     = DIV_N'(hmag);
                    div_d_next     = DIV_D'(TWO_PI_Q);
                    div_neg_next   = hsum[30];
                    div_start_next = 1'b1;
                    state_next     = ST_T_MOD;
                end
            end
            ST_T_MOD: begin
                if (div_done) begin
                    nh_next        = nh_c;
                    cor_ang_next   = hd_reg;
                    cor_start_next = 1'b1;
                    state_next     = ST_T_COS1;
                end
            end
            ST_T_COS1: begin
                if (cor_done) begin
                    s1_next        = cor_sin;
                    c1_next        = cor_cos;
                    cor_ang_next   = nh_reg;
                    cor_start_next = 1'b1;
                    state_next     = ST_T_COS2;
                end
            end
            ST_T_COS2: begin
                if (cor_done) begin
                    dcy_next       = dcy_c;
                    mul_a_next     = abs24(lin_reg);
                    mul_b_next     = MUL_W'(dsx_mag);
                    mul_neg_next   = lin_reg[23] ^ dsx[18];
                    mul_start_next = 1'b1;
                    state_next     = ST_T_MULX;
                end
            end
            ST_T_MULX: begin
                if (mul_done) begin
                    div_n_next     = mul_prod[DIV_N-1:0];
                    div_d_next     = abs24(ang_reg);
                    div_neg_next   = mul_neg_reg ^ ang_reg[23];
                    div_start_next = 1'b1;
                    state_next     = ST_T_DIVX;
                end
            end
            ST_T_DIVX: begin
                if (div_done) begin
                    px_next        = sat32(sumx);
                    mul_a_next     = abs24(lin_reg);
                    mul_b_next     = MUL_W'(dcy_mag);
                    mul_neg_next   = lin_reg[23] ^ dcy_reg[18];
                    mul_start_next = 1'b1;
                    state_next     = ST_T_MULY;
                end
            end
            ST_T_MULY: begin
                if (mul_done) begin
                    div_n_next     = mul_prod[DIV_N-1:0];
                    div_d_next     = abs24(ang_reg);
                    div_neg_next   = mul_neg_reg ^ ang_reg[23];
                    div_start_next = 1'b1;
                    state_next     = ST_T_DIVY;
                end
            end
            ST_T_DIVY: begin
                if (div_done) begin
                    py_next    = sat32(sumy);
                    hd_next    = nh_reg;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    ml_next      = left_reg;
                    mr_next      = right_reg;
                    mx_next      = px_reg;
                    my_next      = py_reg;
                    mh_next      = hd_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            base_reg      <= 16'd26214;
            rad_reg       <= 16'd4915;
            lin_reg       <= '0;
            ang_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            hd_reg        <= '0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lin_reg       <= lin_next;
            ang_reg       <= ang_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            hd_reg        <= hd_next;
            mul_start_reg <= mul_start_next;
            div_start_reg <= div_start_next;
            cor_start_reg <= cor_start_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_WHEEL_BASE:   base_reg <= cfg_wr_data;
                    REG_WHEEL_RADIUS: rad_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        nh_reg      <= nh_next;
        s1_reg      <= s1_next;
        c1_reg      <= c1_next;
        dcy_reg     <= dcy_next;
        numl_reg    <= numl_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        mul_neg_reg <= mul_neg_next;
        div_n_reg   <= div_n_next;
        div_d_reg   <= div_d_next;
        div_neg_reg <= div_neg_next;
        cor_ang_reg <= cor_ang_next;
        ml_reg      <= ml_next;
        mr_reg      <= mr_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        mh_reg      <= mh_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_left_wheel_speed  = ml_reg;
    assign m_right_wheel_speed = mr_reg;
    assign m_out_x             = mx_reg;
    assign m_out_y             = my_reg;
    assign m_out_heading       = mh_reg;

    // one transaction in flight
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_heading < TWO_PI_Q))
        else $error("heading out of range");

    a_angular_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_T_DIVX) |-> (ang_reg != 24'sd0))
        else $error("zero angular divisor");

endmodule

// ----- hdl/ddo_mul.sv -----
module ddo_mul import ddo_pkg::*; #(
    parameter int AW = MUL_W,
    parameter int BW = MUL_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] prod
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [AW+BW-1:0] acc_reg;
    logic [AW+BW-1:0] a_reg;
    logic [BW-1:0]    b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift-add, one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= (AW+BW)'(a);
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + (b_reg[0] ? a_reg : '0);
            a_reg   <= a_reg << 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- hdl/ddo_div.sv -----
module ddo_div import ddo_pkg::*; #(
    parameter int NW = DIV_N,
    parameter int DW = DIV_D
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(NW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            if (!diff[DW+1]) begin
                rem_reg <= diff[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- hdl/ddo_cordic.sv -----
module ddo_cordic import ddo_pkg::*; #(
    parameter int ITER = CORDIC_ITERATIONS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [18:0]              angle,
    output logic                     done,
    output logic signed [TRIG_W-1:0] sin_q,
    output logic signed [TRIG_W-1:0] cos_q
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [4:0]              it_reg;
    logic                    neg_reg;
    logic signed [CRD_W-1:0] x_reg;
    logic signed [CRD_W-1:0] y_reg;
    logic signed [ANG_W-1:0] t_reg;

    logic signed [ANG_W-1:0] ta;
    logic signed [ANG_W-1:0] tb;
    logic                    fneg;
    logic signed [ANG_W-1:0] arc;
    logic signed [CRD_W-1:0] xf;
    logic signed [CRD_W-1:0] yf;
    logic signed [CRD_W-1:0] xr;
    logic signed [CRD_W-1:0] yr;

    // fold the angle into [-pi/2, pi/2]
    always_comb begin
        ta = ANG_W'(angle) <<< ANG_SHIFT;
        if (ta >= PI_Q30) begin
            ta = ta - TWO_PI_Q30;
        end
        tb   = ta;
        fneg = 1'b0;
        if (ta > HALF_PI_Q30) begin
            tb   = ta - PI_Q30;
            fneg = 1'b1;
        end else if (ta < -HALF_PI_Q30) begin
            tb   = ta + PI_Q30;
            fneg = 1'b1;
        end
    end

    assign arc = $signed({5'b0, arc_angle(it_reg)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                it_reg   <= '0;
            end else if (busy_reg) begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == 5'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= GAIN_Q30;
            y_reg   <= '0;
            t_reg   <= tb;
            neg_reg <= fneg;
        end else if (busy_reg) begin
            if (!t_reg[ANG_W-1]) begin
                x_reg <= x_reg - (y_reg >>> it_reg);
                y_reg <= y_reg + (x_reg >>> it_reg);
                t_reg <= t_reg - arc;
            end else begin
                x_reg <= x_reg + (y_reg >>> it_reg);
                y_reg <= y_reg - (x_reg >>> it_reg);
                t_reg <= t_reg + arc;
            end
        end
    end

    assign xf = neg_reg ? -x_reg : x_reg;
    assign yf = neg_reg ? -y_reg : y_reg;
    assign xr = (xf + (CRD_W'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    assign yr = (yf + (CRD_W'(1) <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;

    assign done  = done_reg;
    assign sin_q = yr[TRIG_W-1:0];
    assign cos_q = xr[TRIG_W-1:0];

endmodule

// ----- sim/diff_drive_odometry_tb.sv -----
module diff_drive_odometry_tb import ddo_pkg::*; ();

    localparam int HOLD_LEN    = 1500;
    localparam int SETTLE_CYC  = 300;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [28:0] left;
        logic signed [28:0] right;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [18:0]        hdg;
    } pose_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_addr = REG_WHEEL_BASE;
    logic [15:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_req_type = REQ_VELOCITY;
    logic signed [23:0] s_linear_velocity = '0;
    logic signed [23:0] s_angular_velocity = '0;
    logic [19:0]        s_tick_dt = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [28:0] m_left_wheel_speed;
    logic signed [28:0] m_right_wheel_speed;
    logic signed [31:0] m_out_x;
    logic signed [31:0] m_out_y;
    logic [18:0]        m_out_heading;

    pose_result_t pending_poses[$];
    int  mismatches = 0;
    bit  quiet = 1'b0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_cnt = 0;

    // predictor state
    longint base_m = 26214, radius_m = 4915;
    longint lin_st = 0, ang_st = 0, pos_x = 0, pos_y = 0, hdg_st = 0;

    longint arc_q30[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                            524288, 262144, 131072, 65536, 32768, 16384, 8192,
                            4096, 2048, 1024, 512, 256, 128};

    diff_drive_odometry u_top (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic cordic_sin_cos(input longint ang, output longint s, output longint c);
        longint t, cx, cy, nx;
        bit     neg;
        t = ang * (longint'(1) << ANG_SHIFT);
        cx = longint'(GAIN_Q30);
        cy = 0;
        neg = 1'b0;
        if (t >= PI_Q30) t -= 2 * longint'(PI_Q30);
        if (t > HALF_PI_Q30) begin
            t -= PI_Q30;
            neg = 1'b1;
        end else if (t < -longint'(HALF_PI_Q30)) begin
            t += PI_Q30;
            neg = 1'b1;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
            if (t >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                t -= arc_q30[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                t += arc_q30[i];
            end
            cx = nx;
        end
        if (neg) begin
            cx = -cx;
            cy = -cy;
        end
        s = (cy + (longint'(1) << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
        c = (cx + (longint'(1) << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    endtask

    task automatic predict_pose(input logic rt, input logic signed [23:0] lv,
                                input logic signed [23:0] av, input logic [19:0] dt);
        pose_result_t r;
        longint v, w, rad, lin, rot, lft, rgt, turn, nh, s1, c1, s2, c2, two_pi;
        lft = 0;
        rgt = 0;
        two_pi = longint'(TWO_PI_Q);
        if (rt == REQ_VELOCITY) begin
            v = longint'(lv);
            w = longint'(av);
            rad = radius_m != 0 ? radius_m : 1;
            lin = v * (longint'(2) << FRAC_BITS);
            rot = w * base_m;
            lin_st = v;
            ang_st = w;
            rgt = clamp((lin + rot) / (2 * rad), -268435456, 268435455);
            lft = clamp((lin - rot) / (2 * rad), -268435456, 268435455);
        end else begin
            v = lin_st;
            w = ang_st;
            if ((w < 0 ? -w : w) * 1000 < (longint'(1) << FRAC_BITS)) begin
                w = longint'(W_FLOOR);
                ang_st = w;
            end
            turn = (w * longint'(dt) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            nh = ((hdg_st + turn) % two_pi + two_pi) % two_pi;
            cordic_sin_cos(hdg_st, s1, c1);
            cordic_sin_cos(nh, s2, c2);
            pos_x = clamp(pos_x + (v * (s2 - s1)) / w, -64'sd2147483648, 64'sd2147483647);
            pos_y = clamp(pos_y + (v * (c1 - c2)) / w, -64'sd2147483648, 64'sd2147483647);
            hdg_st = nh;
        end
        r.left = lft[28:0];
        r.right = rgt[28:0];
        r.x = pos_x[31:0];
        r.y = pos_y[31:0];
        r.hdg = hdg_st[18:0];
        pending_poses.insert(pending_poses.size(), r);
    endtask

    task automatic send_item(input logic rt, input logic signed [23:0] lv,
                             input logic signed [23:0] av, input logic [19:0] dt);
        while (!quiet && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_linear_velocity <= lv;
        s_angular_velocity <= av;
        s_tick_dt <= dt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pose(rt, lv, av, dt);
    endtask

    task automatic send_cmd(input logic signed [23:0] lv, input logic signed [23:0] av);
        send_item(REQ_VELOCITY, lv, av, 20'($urandom));
    endtask

    task automatic send_tick(input logic [19:0] dt);
        send_item(REQ_TICK, 24'($urandom), 24'($urandom), dt);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_poses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_WHEEL_BASE) base_m = longint'(val);
        else radius_m = longint'(val);
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [15:0] b, input logic [15:0] r);
        wait_drained();
        write_reg(REG_WHEEL_BASE, b);
        write_reg(REG_WHEEL_RADIUS, r);
    endtask

    task automatic test_directed();
        send_cmd(24'sh7fffff, 24'sh7fffff);
        send_cmd(-24'sh800000, -24'sh800000);
        send_cmd(24'sh7fffff, -24'sh800000);
        send_cmd(24'sd0, 24'sd0);
        send_tick(20'hfffff);
        send_cmd(24'sd65536, 24'sd65);
        send_tick(20'd65536);
        send_cmd(24'sd65536, -24'sd65);
        send_tick(20'd1000);
        send_cmd(-24'sd131072, 24'sd66);
        send_tick(20'd0);
        send_cmd(24'sd300000, 24'sd400000);
        send_tick(20'hfffff);
        send_cmd(-24'sd300000, -24'sd400000);
        send_tick(20'hfffff);
        send_cmd(24'sh7fffff, 24'sd70000);
        send_tick(20'hfffff);
        send_cmd(-24'sh800000, -24'sd66);
        send_tick(20'h80000);
        send_tick(20'h7ffff);
    endtask

    task automatic test_geometry_extremes();
        set_geometry(16'd1, 16'd1);
        send_cmd(24'sh7fffff, 24'sh7fffff);
        send_cmd(-24'sh800000, 24'sd1);
        send_tick(20'd30000);
        set_geometry(16'hffff, 16'hffff);
        send_cmd(24'sh7fffff, -24'sh800000);
        send_cmd(24'sd12345, 24'sd99999);
        send_tick(20'd50000);
        set_geometry(16'hffff, 16'd0);
        send_cmd(24'sh7fffff, 24'sh7fffff);
        send_cmd(-24'sd1000, 24'sd3);
        set_geometry(16'd26214, 16'd4915);
    endtask

    task automatic random_item();
        logic signed [23:0] lv, av;
        if ($urandom_range(99) < 40) begin
            if ($urandom_range(3) == 0) begin
                lv = 24'($urandom);
                av = 24'($urandom);
            end else begin
                lv = 24'($signed($urandom_range(262144)) - 131072);
                av = $urandom_range(7) == 0 ? 24'($signed($urandom_range(130)) - 65)
                                            : 24'($signed($urandom_range(400000)) - 200000);
            end
            send_cmd(lv, av);
        end else begin
            send_tick($urandom_range(3) == 0 ? 20'($urandom) : 20'($urandom_range(4000)));
        end
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) begin
            quiet = (i >= n / 3) && (i < n / 2);
            random_item();
            if (i % 150 == 149)
                set_geometry(16'($urandom), 16'($urandom_range(1, 65535)));
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_seq++;
        for (int i = 0; i < 6; i++) random_item();
        wait_drained();
        for (int i = 0; i < 4; i++) random_item();
    endtask

    // result checker
    always @(posedge aclk) begin
        pose_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: x=%0d y=%0d",
                                               m_out_x, m_out_y);
            end else begin
                e = pending_poses.pop_front();
                if (e.left !== m_left_wheel_speed || e.right !== m_right_wheel_speed ||
                    e.x !== m_out_x || e.y !== m_out_y || e.hdg !== m_out_heading) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp l=%0d r=%0d x=%0d y=%0d h=%0d",
                                 e.left, e.right, e.x, e.y, e.hdg);
                        $display("         got l=%0d r=%0d x=%0d y=%0d h=%0d",
                                 m_left_wheel_speed, m_right_wheel_speed,
                                 m_out_x, m_out_y, m_out_heading);
                    end
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_geometry_extremes();
        test_backpressure();
        test_random(800);
        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
